>>> hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> hdl/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam int unsigned B64D_FIFO_DEPTH = 4;
  localparam logic [7:0]  PAD_CHAR        = 8'h3D;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LENGTH   = 2'd1,
    ST_BAD_CHAR = 2'd2,
    ST_PAD      = 2'd3
  } b64d_status_e;

  // one unit of work for the output side: a decoded quantum or a status
  typedef struct packed {
    logic         is_status;
    b64d_status_e status;
    logic [1:0]   last_idx;   // index of the final byte to send
    logic [23:0]  quantum;
  } b64d_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64d_fifo_stat_t;

  // returns {bad, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

  // keep the most urgent error: lowest nonzero code
  function automatic b64d_status_e note_error(input b64d_status_e cur,
                                              input b64d_status_e code);
    return ((cur == ST_OK) || (code < cur)) ? code : cur;
  endfunction

endpackage

`default_nettype wire

>>> hdl/b64d_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_front import b64d_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire logic [7:0] symbol_i,
  input  wire logic      end_marker_i,
  output logic           push_o,
  output b64d_job_t      job_o
);

  logic [23:0]  quantum_q, quantum_d;
  logic [1:0]   pos_q, pos_d;
  logic [1:0]   pad_q, pad_d;
  logic         seen_q, seen_d;
  b64d_status_e err_q, err_d;

  logic [6:0]   sx;
  logic [5:0]   bits;
  logic [23:0]  shifted;

  assign sx = sextet_of(symbol_i);

  always_comb begin
    quantum_d = quantum_q;
    pos_d     = pos_q;
    pad_d     = pad_q;
    seen_d    = seen_q;
    err_d     = err_q;
    push_o    = 1'b0;
    job_o     = '0;
    bits      = '0;
    shifted   = '0;
    if (accept_i) begin
      if (end_marker_i) begin
        push_o          = 1'b1;
        job_o.is_status = 1'b1;
        job_o.status    = (pos_q != 2'd0) ? ST_LENGTH : err_q;
        quantum_d       = '0;
        pos_d           = '0;
        pad_d           = '0;
        seen_d          = 1'b0;
        err_d           = ST_OK;
      end else begin
        if (seen_q) err_d = note_error(err_d, ST_PAD);
        if (symbol_i == PAD_CHAR) begin
          if (pos_q < 2'd2) err_d = note_error(err_d, ST_PAD);
          else if (pos_q == 2'd2) pad_d[0] = 1'b1;
          else pad_d[1] = 1'b1;
        end else if (sx[6]) begin
          err_d = note_error(err_d, ST_BAD_CHAR);
        end else begin
          bits = sx[5:0];
        end
        shifted = {quantum_q[17:0], bits};
        if (pos_q == 2'd3) begin
          push_o         = 1'b1;
          job_o.quantum  = shifted;
          job_o.last_idx = 2'd2 - {1'b0, pad_d[0]} - {1'b0, pad_d[1]};
          if (pad_d != 2'b00) seen_d = 1'b1;
          quantum_d      = '0;
          pad_d          = '0;
          pos_d          = '0;
        end else begin
          quantum_d = shifted;
          pos_d     = pos_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= '0;
      pos_q     <= '0;
      pad_q     <= '0;
      seen_q    <= 1'b0;
      err_q     <= ST_OK;
    end else begin
      quantum_q <= quantum_d;
      pos_q     <= pos_d;
      pad_q     <= pad_d;
      seen_q    <= seen_d;
      err_q     <= err_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/b64d_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_fifo import b64d_pkg::*; #(
  parameter int unsigned DEPTH = B64D_FIFO_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire b64d_job_t job_i,
  input  wire logic      pop_i,
  output b64d_job_t      head_o,
  output b64d_fifo_stat_t stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64d_job_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) count_d = count_q + CW'(1);
    else if (!push_i && pop_i) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

`default_nettype wire

>>> hdl/b64d_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_back import b64d_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire b64d_job_t   head_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  b64d_job_t  cur_q, cur_d;
  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic       done;
  logic       take;
  logic [7:0] byte_sel;

  assign done = m_axis_tready && valid_q && (idx_q == cur_q.last_idx);
  assign take = !valid_q || done;
  assign pop_o = take && !empty_i;

  always_comb begin
    case (idx_q)
      2'd0:    byte_sel = cur_q.quantum[23:16];
      2'd1:    byte_sel = cur_q.quantum[15:8];
      default: byte_sel = cur_q.quantum[7:0];
    endcase
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {6'd0, cur_q.is_status ? cur_q.status : ST_OK, byte_sel};
  assign m_axis_tuser  = cur_q.is_status;
  assign m_axis_tlast  = (idx_q == cur_q.last_idx);

  always_comb begin
    cur_d   = cur_q;
    valid_d = valid_q;
    idx_d   = idx_q;
    if (take) begin
      valid_d = !empty_i;
      cur_d   = head_i;
      idx_d   = '0;
    end else if (m_axis_tready) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

`default_nettype wire

>>> hdl/base64_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// base64 stream decoder (standard alphabet, '=' padding). one character
// comes in per request on s_axis; a request with tlast set closes the string
// and yields one status item (tuser high) with code 0 ok, 1 length not a
// multiple of four, 2 bad character, 3 misplaced padding. every fourth
// character yields three bytes, fewer where the quantum was padded. bytes
// already sent stand even when the string ends in error, so the consumer
// drops them on a nonzero status. the front end decodes and classifies one
// character every cycle that s_axis_tready is high, handing finished quanta
// and status requests to a short job queue; the back end drains it at one
// result per cycle while m_axis_tready is high, from a registered output
// stage. input therefore runs at one character per cycle while the output
// keeps up; since four characters give at most three bytes the output port
// is the limit only under backpressure, and a full queue then holds off
// s_axis_tready. each quantum is queued, then registered in the output stage.
module base64_stream_decoder import b64d_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = B64D_FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  wire logic        s_axis_tlast,   // end marker
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [9:8] status, rest zero
  output logic             m_axis_tuser,   // [0] is_status
  output logic             m_axis_tlast    // last result of this request
);

  logic            accept;
  logic            push;
  logic            pop;
  b64d_job_t       job_in;
  b64d_job_t       job_head;
  b64d_fifo_stat_t fifo_stat;

  // take a new character whenever the queue has room for what it may cause
  assign s_axis_tready = !fifo_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // front end: sextet lookup, quantum assembly, padding and error tracking
  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .symbol_i     (s_axis_tdata),
    .end_marker_i (s_axis_tlast),
    .push_o       (push),
    .job_o        (job_in)
  );

  // job queue parting decode from byte output
  b64d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .head_o (job_head),
    .stat_o (fifo_stat)
  );

  // back end: one byte or status per cycle while m_axis_tready is high
  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (job_head),
    .empty_i       (fifo_stat.empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // queue must never overflow or underflow
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push && fifo_stat.full && !pop, "job queue overflow")
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop && fifo_stat.empty, "job queue underflow")
  // a status item is always the single result of its request
  `ASSERT_ALWAYS(a_status_last, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "status item without tlast")
  // data bytes carry a zero status field
  `ASSERT_ALWAYS(a_data_ok, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[9:8] == 2'd0), "data item with status")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import b64d_pkg::*;

  localparam int IDLE_LIMIT   = 3000;  // cycles with no handshake before giving up
  localparam int ITEMS_TARGET = 260;
  localparam int PRINT_CAP    = 20;

  typedef struct packed {
    logic [7:0]   octet;
    logic         is_stat;
    b64d_status_e code;
    logic         last;
  } decoded_item_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] symbol
  logic        s_axis_tlast  = 1'b0;   // end marker
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] data_byte, [9:8] status
  logic        m_axis_tuser;           // [0] is_status
  logic        m_axis_tlast;

  base64_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  int    sextet_tab [256];

  // decoder state as the predictor sees it
  logic [23:0]  acc_bits;
  logic [1:0]   slot;
  logic [1:0]   pad_mark;          // bit0 '=' in third place, bit1 '=' in fourth
  logic         pad_quantum_done;
  b64d_status_e worst_err;

  decoded_item_t expected_q [$];
  logic [7:0]    text_buf [$];

  int  mismatches    = 0;
  int  items_sent    = 0;
  int  strings_sent  = 0;
  int  results_seen  = 0;
  int  status_seen [4];
  int  hold_off_left = 0;
  int  idle_cycles   = 0;
  bit  no_gaps       = 1'b0;
  bit  offering      = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic add_expected(input decoded_item_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic add_char(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endtask

  task automatic clear_decode_state();
    acc_bits         = '0;
    slot             = '0;
    pad_mark         = '0;
    pad_quantum_done = 1'b0;
    worst_err        = ST_OK;
  endtask

  // lower code wins, ok never overrides
  task automatic keep_worst(input b64d_status_e code);
    if (worst_err == ST_OK || worst_err > code) worst_err = code;
  endtask

  // works out what one accepted request should produce
  task automatic predict_decode(input logic [7:0] sym, input logic endm);
    decoded_item_t r;
    logic [5:0]    bits;
    int            n;
    if (endm) begin
      r.octet   = 8'h00;
      r.is_stat = 1'b1;
      r.code    = (slot != 2'd0) ? ST_LENGTH : worst_err;
      r.last    = 1'b1;
      add_expected(r);
      status_seen[r.code]++;
      strings_sent++;
      clear_decode_state();
      return;
    end
    if (pad_quantum_done) keep_worst(ST_PAD);
    bits = '0;
    if (sym == PAD_CHAR) begin
      if (slot < 2'd2) keep_worst(ST_PAD);
      else if (slot == 2'd2) pad_mark[0] = 1'b1;
      else pad_mark[1] = 1'b1;
    end else if (sextet_tab[sym] < 0) begin
      keep_worst(ST_BAD_CHAR);
    end else begin
      bits = sextet_tab[sym][5:0];
    end
    acc_bits = {acc_bits[17:0], bits};
    if (slot != 2'd3) begin
      slot = slot + 2'd1;
      return;
    end
    n = 3 - int'(pad_mark[0]) - int'(pad_mark[1]);
    for (int k = 0; k < n; k++) begin
      r.octet   = acc_bits[23 - 8 * k -: 8];
      r.is_stat = 1'b0;
      r.code    = ST_OK;
      r.last    = (k == n - 1);
      add_expected(r);
    end
    if (pad_mark != 2'b00) pad_quantum_done = 1'b1;
    acc_bits = '0;
    pad_mark = '0;
    slot     = '0;
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // offers one request and waits for its handshake; returns at that edge
  task automatic send_symbol(input logic [7:0] sym, input logic endm);
    int gap;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 99) < 25) gap = pick_gap();
    if (gap != 0) begin
      if (offering) begin
        s_axis_tvalid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= endm;
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_decode(sym, endm);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_symbol(s.getc(i), 1'b0);
  endtask

  task automatic send_buffer();
    foreach (text_buf[i]) send_symbol(text_buf[i], 1'b0);
    send_symbol(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic idle_input();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // well-formed encoding of nbytes random bytes, padded to whole quanta
  task automatic build_encoded(input int nbytes);
    logic [23:0] grp;
    int          take;
    text_buf.delete();
    for (int i = 0; i < nbytes; i += 3) begin
      take = (nbytes - i >= 3) ? 3 : nbytes - i;
      grp  = 24'($urandom);
      for (int k = 0; k < 4; k++) begin
        if (k <= take) add_char(alphabet.getc(int'(grp[23 - 6 * k -: 6])));
        else add_char(PAD_CHAR);
      end
    end
  endtask

  task automatic send_random_string();
    int kind;
    int pos;
    kind = $urandom_range(0, 99);
    build_encoded($urandom_range(0, 99) < 90 ? $urandom_range(0, 6) : $urandom_range(7, 12));
    if (kind >= 75 && kind < 88 && text_buf.size() != 0) begin
      // one character swapped for anything, padding included
      pos = $urandom_range(0, text_buf.size() - 1);
      text_buf[pos] = $urandom_range(0, 3) == 0 ? PAD_CHAR : 8'($urandom_range(0, 255));
    end else if (kind >= 88 && kind < 94) begin
      if (text_buf.size() != 0 && $urandom_range(0, 1) == 1) void'(text_buf.pop_back());
      else add_char(alphabet.getc($urandom_range(0, 63)));
    end else if (kind >= 94) begin
      text_buf.delete();
      repeat ($urandom_range(0, 9)) begin
        case ($urandom_range(0, 2))
          0:       add_char(PAD_CHAR);
          1:       add_char(alphabet.getc($urandom_range(0, 63)));
          default: add_char(8'($urandom_range(0, 255)));
        endcase
      end
    end
    send_buffer();
  endtask

  // end marker alone, with an all-ones symbol that must be ignored
  task automatic test_empty_string();
    send_symbol(8'hFF, 1'b1);
  endtask

  // extremes of the alphabet, then a quantum closed by two pads
  task automatic test_alphabet_extremes();
    send_text("A/+z09==");
    send_symbol(8'h00, 1'b1);
  endtask

  // pad then data in one quantum, data after a padded quantum, lone pad
  task automatic test_padding_rules();
    send_text("Ta=bQQ==");
    send_symbol(8'h7F, 1'b1);
    send_text("=");
    send_symbol(8'h80, 1'b1);
  endtask

  // bad character with the top bit set beats early padding in second place
  task automatic test_error_priority();
    send_symbol(8'h80, 1'b0);
    send_text("=A=");
    send_symbol(8'h3D, 1'b1);
  endtask

  task automatic test_random_strings(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_string();
  endtask

  // output held off for a long stretch while the sender keeps offering long
  // strings, so the job queue fills and input requests are held back
  task automatic test_output_backpressure();
    hold_off_left = 150;
    no_gaps       = 1'b1;
    repeat (3) begin
      build_encoded(9);
      send_buffer();
    end
    no_gaps = 1'b0;
    idle_input();
    wait_drained();
  endtask

  task automatic test_no_idle_run();
    no_gaps = 1'b1;
    test_random_strings(30);
    no_gaps = 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    decoded_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[7:0] !== want.octet)
          report_mismatch($sformatf("data_byte expected %h got %h", want.octet,
                                    m_axis_tdata[7:0]));
        if (m_axis_tdata[9:8] !== want.code)
          report_mismatch($sformatf("status expected %0d got %0d", want.code,
                                    m_axis_tdata[9:8]));
        if (m_axis_tuser !== want.is_stat)
          report_mismatch($sformatf("is_status expected %b got %b", want.is_stat,
                                    m_axis_tuser));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last expected %b got %b", want.last, m_axis_tlast));
      end
    end
  end

  // receiver: random stalls, plus the long hold-off when asked
  initial begin : sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 99) < 15) stall_left = pick_gap();
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    for (int i = 0; i < 256; i++) sextet_tab[i] = -1;
    for (int i = 0; i < 64; i++) sextet_tab[alphabet.getc(i)] = i;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    clear_decode_state();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_string();
    test_alphabet_extremes();
    test_padding_rules();
    test_error_priority();
    test_random_strings(120);
    idle_input();
    test_output_backpressure();
    test_no_idle_run();
    while (items_sent < ITEMS_TARGET) send_random_string();

    idle_input();
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests in %0d strings, %0d results checked",
             items_sent, strings_sent, results_seen);
    $display("status mix: ok %0d, length %0d, bad char %0d, padding %0d",
             status_seen[ST_OK], status_seen[ST_LENGTH], status_seen[ST_BAD_CHAR],
             status_seen[ST_PAD]);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, expected_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
